// ----- rtl/rfx_pkg.sv -----
// Shared types, constants and saturating helpers for the Rusanov flux pipeline.
// Used by every module under rtl except rfx_pipe; depends on nothing.
package rfx_pkg;

  localparam int W  = 64;
  localparam int MW = 62;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int               HEAT_W     = 18;
  localparam int               HEAT_FRAC  = 16;
  localparam logic [HEAT_W-1:0] HEAT_RESET = 18'd91750;

  typedef logic signed [W-1:0] wide_t;

  localparam wide_t      WIDE_MAX = {2'b00, {(W-2){1'b1}}};
  localparam logic [MW-1:0] MAG_MAX = '1;

  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = MW + 2;

  localparam int ST_KSUM = MUL_LAT + 1;
  localparam int ST_KQ   = ST_KSUM + DIV_LAT;
  localparam int ST_EINT = ST_KQ + 1;
  localparam int ST_PRES = ST_EINT + MUL_LAT;
  localparam int ST_GP   = ST_PRES + MUL_LAT;
  localparam int ST_CQ   = ST_GP + DIV_LAT;
  localparam int ST_FIN  = ST_PRES + 1;
  localparam int ST_FMUL = ST_FIN + MUL_LAT;
  localparam int ST_FLUX = ST_FMUL + 1;

  function automatic int sqrt_lat(int f);
    return (MW + 1 + f) / 2 + 1;
  endfunction

  function automatic wide_t sat_w(logic signed [W+1:0] x);
    if (x > WIDE_MAX) return WIDE_MAX;
    if (x < -WIDE_MAX) return -WIDE_MAX;
    return W'(x);
  endfunction

  function automatic wide_t add_w(wide_t a, wide_t b);
    return sat_w((W+2)'(a) + (W+2)'(b));
  endfunction

  function automatic wide_t sub_w(wide_t a, wide_t b);
    return sat_w((W+2)'(a) - (W+2)'(b));
  endfunction

  function automatic logic [MW-1:0] mag_w(wide_t x);
    wide_t n;
    n = -x;
    return x[W-1] ? n[MW-1:0] : x[MW-1:0];
  endfunction

endpackage

// ----- rtl/rfx_pipe.sv -----
// Delay line of enabled registers that keeps operands aligned with the datapath.
// Depends on nothing.
module rfx_pipe #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[DEPTH-1];

endmodule

// ----- rtl/rfx_mul.sv -----
// Four-stage saturating fixed-point multiplier built from 31x31 partial products.
// Depends on rfx_pkg.
module rfx_mul #(
  parameter int FRAC_BITS = rfx_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  rfx_pkg::wide_t a,
  input  rfx_pkg::wide_t b,
  output rfx_pkg::wide_t p
);
  import rfx_pkg::*;

  localparam int HW = MW / 2;

  logic [MW-1:0]   am, bm;
  logic            n1, n2, n3;
  logic [2*HW-1:0] p00, p01, p10, p11;
  logic [2*MW-1:0] prod;
  logic [2*MW-1:0] q;
  logic [MW-1:0]   m;
  wide_t           mw;

  always_comb begin
    q  = prod >> FRAC_BITS;
    m  = (q > (2*MW)'(MAG_MAX)) ? MAG_MAX : q[MW-1:0];
    mw = {2'b00, m};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am   <= mag_w(a);
      bm   <= mag_w(b);
      n1   <= a[W-1] ^ b[W-1];
      p00  <= am[HW-1:0] * bm[HW-1:0];
      p01  <= am[HW-1:0] * bm[MW-1:HW];
      p10  <= am[MW-1:HW] * bm[HW-1:0];
      p11  <= am[MW-1:HW] * bm[MW-1:HW];
      n2   <= n1;
      prod <= (2*MW)'(p00) + ((2*MW)'(p01) << HW) + ((2*MW)'(p10) << HW)
              + ((2*MW)'(p11) << (2*HW));
      n3   <= n2;
      p    <= n3 ? -mw : mw;
    end
  end

endmodule

// ----- rtl/rfx_div.sv -----
// Pipelined radix-2 restoring divider, one quotient bit per stage, saturating.
// Depends on rfx_pkg.
module rfx_div #(
  parameter int FRAC_BITS = rfx_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  rfx_pkg::wide_t a,
  input  rfx_pkg::wide_t b,
  output rfx_pkg::wide_t q
);
  import rfx_pkg::*;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [MW-1:0] nq;
    logic [MW-1:0] d;
    logic          neg;
    logic          spec;
    logic          zero;
  } div_stage_t;

  div_stage_t    st  [MW+1];
  div_stage_t    nxt [MW];
  div_stage_t    prep;
  logic [MW-1:0] na, dm;
  wide_t         qw, res;

  always_comb begin
    na        = mag_w(a);
    dm        = mag_w(b);
    prep.d    = dm;
    prep.rem  = na >> (MW - FRAC_BITS);
    prep.nq   = na << FRAC_BITS;
    prep.neg  = (dm == '0) ? a[W-1] : (a[W-1] ^ b[W-1]);
    prep.spec = (dm == '0) || ((na >> (MW - FRAC_BITS)) >= dm);
    prep.zero = (dm == '0) && (a == '0);
  end

  always_comb begin
    logic [MW:0] sh;
    logic        ge;
    for (int i = 0; i < MW; i++) begin
      sh         = {st[i].rem, st[i].nq[MW-1]};
      ge         = sh >= {1'b0, st[i].d};
      nxt[i]     = st[i];
      nxt[i].rem = ge ? MW'(sh - {1'b0, st[i].d}) : sh[MW-1:0];
      nxt[i].nq  = {st[i].nq[MW-2:0], ge};
    end
  end

  always_comb begin
    qw = {2'b00, st[MW].nq};
    if (st[MW].spec) begin
      res = st[MW].zero ? '0 : (st[MW].neg ? -WIDE_MAX : WIDE_MAX);
    end else begin
      res = st[MW].neg ? -qw : qw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= prep;
      for (int i = 0; i < MW; i++) st[i+1] <= nxt[i];
      q <= res;
    end
  end

endmodule

// ----- rtl/rfx_sqrt.sv -----
// Pipelined digit-by-digit square root of a Q value, one root bit per stage.
// Depends on rfx_pkg.
module rfx_sqrt #(
  parameter int FRAC_BITS = rfx_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  rfx_pkg::wide_t x,
  output rfx_pkg::wide_t r
);
  import rfx_pkg::*;

  localparam int RB = (MW + 1 + FRAC_BITS) / 2;
  localparam int NW = 2 * RB;

  typedef struct packed {
    logic [RB+1:0] rem;
    logic [RB-1:0] root;
    logic [NW-1:0] nb;
  } sq_stage_t;

  sq_stage_t     st  [RB+1];
  sq_stage_t     nxt [RB];
  sq_stage_t     prep;
  logic [MW-1:0] n;

  always_comb begin
    n         = x[W-1] ? '0 : x[MW-1:0];
    prep.rem  = '0;
    prep.root = '0;
    prep.nb   = NW'({n, {FRAC_BITS{1'b0}}});
  end

  always_comb begin
    logic [RB+3:0] sh, trial;
    logic          ge;
    for (int i = 0; i < RB; i++) begin
      sh          = {st[i].rem, st[i].nb[NW-1 -: 2]};
      trial       = (RB+4)'({st[i].root, 2'b01});
      ge          = sh >= trial;
      nxt[i].rem  = ge ? (RB+2)'(sh - trial) : sh[RB+1:0];
      nxt[i].root = {st[i].root[RB-2:0], ge};
      nxt[i].nb   = st[i].nb << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= prep;
      for (int i = 0; i < RB; i++) st[i+1] <= nxt[i];
    end
  end

  assign r = W'(st[RB].root);

endmodule

// ----- rtl/rfx_side.sv -----
// One side of a face: pressure, physical normal flux and wave speed of a cell state.
// Depends on rfx_pkg, rfx_pipe, rfx_mul, rfx_div and rfx_sqrt.
module rfx_side #(
  parameter int FRAC_BITS = rfx_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  rfx_pkg::wide_t u0,
  input  rfx_pkg::wide_t u1,
  input  rfx_pkg::wide_t u2,
  input  rfx_pkg::wide_t u3,
  input  logic           radial,
  input  rfx_pkg::wide_t g,
  input  rfx_pkg::wide_t gm1,
  output rfx_pkg::wide_t pres,
  output rfx_pkg::wide_t flux [4],
  output rfx_pkg::wide_t spd
);
  import rfx_pkg::*;

  localparam int ST_C = ST_CQ + sqrt_lat(FRAC_BITS);

  wide_t sq1, sq2, ksum, u0_a, kq, u3_a, eint, gm1_a, g_a, u0_b, gp, cq, c;
  wide_t vn, vn_a, vn_b, u3_b, e3, u0_f, u1_f, u2_f, p_f;
  wide_t fm [4];
  logic  rad_f;

  rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_sq1 (.clk, .en, .a(u1), .b(u1), .p(sq1));
  rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_sq2 (.clk, .en, .a(u2), .b(u2), .p(sq2));

  rfx_pipe #(.WIDTH(W), .DEPTH(ST_KSUM)) u_d_u0a (.clk, .en, .d(u0), .q(u0_a));
  rfx_div #(.FRAC_BITS(FRAC_BITS)) u_kdiv (.clk, .en, .a(ksum), .b(u0_a), .q(kq));

  rfx_pipe #(.WIDTH(W), .DEPTH(ST_KQ)) u_d_u3a (.clk, .en, .d(u3), .q(u3_a));
  rfx_pipe #(.WIDTH(W), .DEPTH(ST_EINT)) u_d_gm1 (.clk, .en, .d(gm1), .q(gm1_a));
  rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_pmul (.clk, .en, .a(gm1_a), .b(eint), .p(pres));

  rfx_pipe #(.WIDTH(W), .DEPTH(ST_PRES)) u_d_g (.clk, .en, .d(g), .q(g_a));
  rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_gpmul (.clk, .en, .a(g_a), .b(pres), .p(gp));

  rfx_pipe #(.WIDTH(W), .DEPTH(ST_GP - ST_KSUM)) u_d_u0b (.clk, .en, .d(u0_a), .q(u0_b));
  rfx_div #(.FRAC_BITS(FRAC_BITS)) u_cdiv (.clk, .en, .a(gp), .b(u0_b), .q(cq));
  rfx_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (.clk, .en, .x(cq), .r(c));

  rfx_div #(.FRAC_BITS(FRAC_BITS)) u_vdiv (
    .clk, .en, .a(radial ? u2 : u1), .b(u0), .q(vn)
  );
  rfx_pipe #(.WIDTH(W), .DEPTH(ST_FIN - DIV_LAT)) u_d_vna (.clk, .en, .d(vn), .q(vn_a));
  rfx_pipe #(.WIDTH(W), .DEPTH(ST_C - ST_FIN)) u_d_vnb (.clk, .en, .d(vn_a), .q(vn_b));

  rfx_pipe #(.WIDTH(W), .DEPTH(ST_PRES - ST_KQ)) u_d_u3b (.clk, .en, .d(u3_a), .q(u3_b));
  rfx_pipe #(.WIDTH(3*W), .DEPTH(ST_FIN)) u_d_uf (
    .clk, .en, .d({u2, u1, u0}), .q({u2_f, u1_f, u0_f})
  );
  rfx_pipe #(.WIDTH(W), .DEPTH(ST_FMUL - ST_PRES)) u_d_pf (.clk, .en, .d(pres), .q(p_f));
  rfx_pipe #(.WIDTH(1), .DEPTH(ST_FMUL)) u_d_rad (.clk, .en, .d(radial), .q(rad_f));

  rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_f0 (.clk, .en, .a(u0_f), .b(vn_a), .p(fm[0]));
  rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_f1 (.clk, .en, .a(u1_f), .b(vn_a), .p(fm[1]));
  rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_f2 (.clk, .en, .a(u2_f), .b(vn_a), .p(fm[2]));
  rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_f3 (.clk, .en, .a(e3), .b(vn_a), .p(fm[3]));

  always_ff @(posedge clk) begin
    if (en) begin
      ksum    <= add_w(sq1, sq2);
      eint    <= sub_w(u3_a, kq >>> 1);
      e3      <= add_w(u3_b, pres);
      flux[0] <= fm[0];
      flux[1] <= add_w(fm[1], rad_f ? '0 : p_f);
      flux[2] <= add_w(fm[2], rad_f ? p_f : '0);
      flux[3] <= fm[3];
      spd     <= add_w(vn_b[W-1] ? -vn_b : vn_b, c);
    end
  end

endmodule

// ----- rtl/rusanov_euler_flux.sv -----
// Rusanov face flux for 2D Euler: the latency from input beat to output beat is
// set by the chain of the kinetic-energy divider, two multipliers, the sound-speed
// divider and the square root.
// Throughput one beat per clock; the whole pipeline holds while the output stalls.
// Synchronous reset clears all valid bits and loads heat_ratio with 1.4.
// Depends on rfx_pkg, rfx_pipe, rfx_mul, rfx_div, rfx_sqrt and rfx_side.
module rusanov_euler_flux #(
  parameter int DATA_WIDTH = rfx_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rfx_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    heat_ratio_we,
  input  logic [rfx_pkg::HEAT_W-1:0]              heat_ratio,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // left_density, left_mom_x, left_mom_r, left_energy,
  // right_density, right_mom_x, right_mom_r, right_energy
  input  logic [8*DATA_WIDTH-1:0]                 s_tdata,
  // normal_axis
  input  logic [0:0]                              s_tuser,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // flux_density, flux_mom_x, flux_mom_r, flux_energy, zero pad
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
  // invalid_state
  output logic [0:0]                              m_tuser
);
  import rfx_pkg::*;

  localparam int OUT_W  = ((4*DATA_WIDTH+7)/8)*8;
  localparam int ST_C   = ST_CQ + sqrt_lat(FRAC_BITS);
  localparam int ST_S   = ST_C + 2;
  localparam int ST_D   = ST_S + MUL_LAT;
  localparam int ST_OUT = ST_D + 1;
  localparam int SH_UP  = (FRAC_BITS >= HEAT_FRAC) ? FRAC_BITS - HEAT_FRAC : 0;
  localparam int SH_DN  = (FRAC_BITS >= HEAT_FRAC) ? 0 : HEAT_FRAC - FRAC_BITS;

  logic [HEAT_W-1:0] heat;
  logic [ST_OUT:0]   vld;
  logic              adv;

  wide_t uin [8];
  wide_t ul [4];
  wide_t ur [4];
  wide_t diff [4];
  wide_t diff_s [4];
  wide_t sum [4];
  wide_t sum_d [4];
  wide_t diss [4];
  wide_t fl [4];
  wide_t fr [4];
  wide_t g, gm1, g_in, p_l, p_r, spd_l, spd_r, s;
  logic  radial, bad0, bad0_p, bad_p, bad_d;
  logic [4*DATA_WIDTH-1:0] out_d;

  function automatic logic [DATA_WIDTH-1:0] to_field(wide_t x);
    wide_t hi, lo, v;
    hi = (wide_t'(1) <<< (DATA_WIDTH-1)) - 1;
    lo = -hi - 1;
    v  = x;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic wide_t half_w(wide_t x);
    wide_t m;
    m = x[W-1] ? -x : x;
    m = m >>> 1;
    return x[W-1] ? -m : m;
  endfunction

  assign adv      = !vld[ST_OUT] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[ST_OUT];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      uin[k] = sat_w((W+2)'($signed(s_tdata[k*DATA_WIDTH +: DATA_WIDTH])));
    end
    g_in = (wide_t'(heat) << SH_UP) >> SH_DN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat <= HEAT_RESET;
      vld  <= '0;
    end else begin
      if (heat_ratio_we) heat <= heat_ratio;
      if (adv) vld <= {vld[ST_OUT-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        ul[k]   <= uin[k];
        ur[k]   <= uin[4+k];
        diff[k] <= sub_w(ur[k], ul[k]);
        sum[k]  <= add_w(fl[k], fr[k]);
      end
      radial <= s_tuser[0];
      g      <= g_in;
      gm1    <= sub_w(g_in, wide_t'(1) << FRAC_BITS);
      bad0   <= (uin[0] <= 0) || (uin[4] <= 0);
      s      <= (spd_l > spd_r) ? spd_l : spd_r;
    end
  end

  rfx_side #(.FRAC_BITS(FRAC_BITS)) u_left (
    .clk, .en(adv), .u0(ul[0]), .u1(ul[1]), .u2(ul[2]), .u3(ul[3]), .radial,
    .g, .gm1, .pres(p_l), .flux(fl), .spd(spd_l)
  );

  rfx_side #(.FRAC_BITS(FRAC_BITS)) u_right (
    .clk, .en(adv), .u0(ur[0]), .u1(ur[1]), .u2(ur[2]), .u3(ur[3]), .radial,
    .g, .gm1, .pres(p_r), .flux(fr), .spd(spd_r)
  );

  rfx_pipe #(.WIDTH(1), .DEPTH(ST_PRES)) u_d_bad0 (.clk, .en(adv), .d(bad0), .q(bad0_p));
  assign bad_p = bad0_p || p_l[W-1] || p_r[W-1];
  rfx_pipe #(.WIDTH(1), .DEPTH(ST_D - ST_PRES)) u_d_bad (
    .clk, .en(adv), .d(bad_p), .q(bad_d)
  );

  rfx_pipe #(.WIDTH(4*W), .DEPTH(ST_S - 1)) u_d_diff (
    .clk, .en(adv), .d({diff[3], diff[2], diff[1], diff[0]}),
    .q({diff_s[3], diff_s[2], diff_s[1], diff_s[0]})
  );

  rfx_pipe #(.WIDTH(4*W), .DEPTH(ST_D - ST_FLUX - 1)) u_d_sum (
    .clk, .en(adv), .d({sum[3], sum[2], sum[1], sum[0]}),
    .q({sum_d[3], sum_d[2], sum_d[1], sum_d[0]})
  );

  for (genvar k = 0; k < 4; k++) begin : g_diss
    rfx_mul #(.FRAC_BITS(FRAC_BITS)) u_dmul (
      .clk, .en(adv), .a(s), .b(diff_s[k]), .p(diss[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      out_d[k*DATA_WIDTH +: DATA_WIDTH] = bad_d ? '0 :
        to_field(half_w(sub_w(sum_d[k], diss[k])));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata    <= OUT_W'(out_d);
      m_tuser[0] <= bad_d;
    end
  end

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("invalid beat carries nonzero flux");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved during output stall");

  a_bubble: assert property (@(posedge clk) disable iff (rst)
    !vld[ST_OUT-1] && s_tready |=> !m_tvalid)
    else $error("output beat without a source item");

endmodule
